### rtl/pud_pkg.sv
// shared types, character constants and hex helper for the percent unescape decoder
package pud_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [3:0] HEX_ALPHA_BASE = 4'd10;

    localparam int unsigned CAP_W = 16;

    typedef enum logic [1:0] {
        PH_PLAIN  = 2'd0,
        PH_PCT    = 2'd1,
        PH_DIGIT1 = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [3:0]         high_nibble;
        logic [CAP_W-1:0]   out_count;
        logic               failed;
    } pud_state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_data;
        logic       done_res;
        logic       ok;
    } pud_result_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_value(input logic [7:0] c);
        hex_digit_t h;
        logic [7:0] d;
        h = '0;
        d = '0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = c - CH_ZERO;
            h.valid = 1'b1;
            h.value = d[3:0];
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
        begin
            d = c - CH_LOWER_A;
            h.valid = 1'b1;
            h.value = d[3:0] + HEX_ALPHA_BASE;
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
        begin
            d = c - CH_UPPER_A;
            h.valid = 1'b1;
            h.value = d[3:0] + HEX_ALPHA_BASE;
        end
        return h;
    endfunction

endpackage

### rtl/pud_step.sv
// combinational decode of one character against the string state
module pud_step (
    input  pud_pkg::pud_state_t          state,
    input  logic [7:0]                   in_byte,
    input  logic                         is_last,
    input  logic [pud_pkg::CAP_W-1:0]    capacity,
    output pud_pkg::pud_state_t          state_next,
    output pud_pkg::pud_result_t         result,
    output logic                         emit
);
    import pud_pkg::*;

    hex_digit_t hd;
    pud_state_t s;
    logic       data;
    logic [7:0] dbyte;

    assign hd = hex_value(in_byte);

    always_comb
    begin
        s     = state;
        data  = 1'b0;
        dbyte = '0;
        if (!state.failed)
        begin
            unique case (state.phase)
                PH_PCT:
                begin
                    if (!hd.valid || is_last)
                    begin
                        s.failed = 1'b1;
                    end
                    else
                    begin
                        s.high_nibble = hd.value;
                        s.phase       = PH_DIGIT1;
                    end
                end
                PH_DIGIT1:
                begin
                    if (!hd.valid)
                    begin
                        s.failed = 1'b1;
                    end
                    else
                    begin
                        dbyte   = {state.high_nibble, hd.value};
                        data    = 1'b1;
                        s.phase = PH_PLAIN;
                    end
                end
                default:
                begin
                    // unused phase code decodes as plain text
                    s.phase = PH_PLAIN;
                    if (state.out_count >= capacity)
                    begin
                        s.failed = 1'b1;
                    end
                    else if (in_byte == CH_PLUS)
                    begin
                        dbyte = CH_SPACE;
                        data  = 1'b1;
                    end
                    else if (in_byte == CH_PERCENT)
                    begin
                        // lone final percent is dropped
                        if (!is_last)
                            s.phase = PH_PCT;
                    end
                    else
                    begin
                        dbyte = in_byte;
                        data  = 1'b1;
                    end
                end
            endcase
            if (data)
                s.out_count = state.out_count + 1'b1;
        end

        result.out_byte = dbyte;
        result.has_data = data;
        result.done_res = is_last;
        result.ok       = is_last && !s.failed;
        emit            = data || is_last;

        if (is_last)
            state_next = '{phase: PH_PLAIN, high_nibble: 4'd0, out_count: '0, failed: 1'b0};
        else
            state_next = s;
    end

endmodule

### rtl/pud_out_stage.sv
// result register and a skid entry for one result pushed during a stall
module pud_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pud_pkg::pud_result_t  push_data,
    output logic                  push_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pud_pkg::pud_result_t  out_data
);
    import pud_pkg::*;

    logic        out_valid_reg;
    logic        skid_valid_reg;
    pud_result_t out_data_reg;
    pud_result_t skid_data_reg;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (push)
                out_data_reg <= push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule

### rtl/percent_unescape_decoder.sv
// top level of the form-style percent unescape decoder
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  input   | in        | in_valid / in_ready   | in_byte, is_last
//  result  | out       | out_valid / out_ready | out_byte, has_data, done_res, ok
//  config  | in        | cfg_we                | cfg_wdata (out_capacity)
//
// one character per cycle unless a result stall holds the flow: an input register,
// the decode step and the result register, through which each result passes in order
// a character that yields no result is consumed without touching the result side
// reset clears the string state and sets out_capacity to 65535
// a result stall fills the skid entry, then holds the input register and in_ready
module percent_unescape_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        has_data,
    output logic        done_res,
    output logic        ok,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import pud_pkg::*;

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             is_last_reg;
    logic [CAP_W-1:0] capacity_reg;
    pud_state_t       state_reg;
    pud_state_t       state_next;
    pud_result_t      step_result;
    pud_result_t      out_data;
    logic             step_emit;
    logic             stage_ready;
    logic             step_fire;

    assign step_fire = in_valid_reg && stage_ready;
    assign in_ready  = !in_valid_reg || stage_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            capacity_reg <= {CAP_W{1'b1}};
            state_reg    <= '{phase: PH_PLAIN, high_nibble: 4'd0, out_count: '0, failed: 1'b0};
        end
        else
        begin
            if (cfg_we)
                capacity_reg <= cfg_wdata;
            if (in_ready)
                in_valid_reg <= in_valid;
            if (step_fire)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= in_byte;
            is_last_reg <= is_last;
        end
    end

    pud_step u_step (
        .state      (state_reg),
        .in_byte    (in_byte_reg),
        .is_last    (is_last_reg),
        .capacity   (capacity_reg),
        .state_next (state_next),
        .result     (step_result),
        .emit       (step_emit)
    );

    pud_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step_fire && step_emit),
        .push_data  (step_result),
        .push_ready (stage_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign out_byte = out_data.out_byte;
    assign has_data = out_data.has_data;
    assign done_res = out_data.done_res;
    assign ok       = out_data.ok;

endmodule

### rtl/pud_checker.sv
// port-level checks on the decoder results, bound to the top level
module pud_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       has_data,
    input  logic       done_res,
    input  logic       ok
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // every result carries a byte or closes a string
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (has_data || done_res))
        else $error("empty result");

    a_ok_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> !ok)
        else $error("ok set without done");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_data |-> (out_byte == 8'd0))
        else $error("byte not zero without data");

endmodule

bind percent_unescape_decoder pud_checker u_pud_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .has_data  (has_data),
    .done_res  (done_res),
    .ok        (ok)
);

### tb/tb_percent_unescape_decoder.sv
// self-checking testbench for the percent unescape decoder with random stimulus and stalls
`timescale 1ns / 100ps

module tb_percent_unescape_decoder;
    import pud_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
    } src_char_t;

    typedef enum int {
        STR_CLEAN,
        STR_LONE_PCT,
        STR_SHORT_ESC,
        STR_BAD_HEX,
        STR_NOISE
    } str_kind_t;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_SPARSE
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = 8'h00;
    logic        is_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        has_data;
    logic        done_res;
    logic        ok;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;

    // decoder state as predicted from accepted characters
    phase_t      dec_phase = PH_PLAIN;
    logic [3:0]  dec_hi = 4'h0;
    logic [15:0] dec_count = 16'h0000;
    logic        dec_failed = 1'b0;
    logic [15:0] cap_limit = 16'hFFFF;

    src_char_t   source_q[$];
    pud_result_t decoded_q[$];
    logic [7:0]  str_buf[$];

    int          err_count = 0;
    logic        in_taken = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          tx_gap_max = 0;
    rx_mode_t    rx_mode = RX_ALWAYS;
    int          rx_tick = 0;
    int          hold_len = 0;
    int          hold_left = 0;
    logic        hold_go = 1'b0;
    logic        hold_seen = 1'b0;

    percent_unescape_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .has_data  (has_data),
        .done_res  (done_res),
        .ok        (ok),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < 50)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c - CH_ZERO);
        if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            return c - CH_LOWER_A + 10;
        if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            return c - CH_UPPER_A + 10;
        return -1;
    endfunction

    // one accepted source character; queues the result it causes, if any
    task automatic decode_char(input logic [7:0] c, input logic is_end);
        logic        data;
        logic [7:0]  val;
        int          nib;
        pud_result_t res;
        data = 1'b0;
        val = 8'h00;
        if (!dec_failed)
        begin
            nib = hex_nibble(c);
            if (dec_phase == PH_PCT)
            begin
                if (nib < 0 || is_end)
                    dec_failed = 1'b1;
                else
                begin
                    dec_hi = nib[3:0];
                    dec_phase = PH_DIGIT1;
                end
            end
            else if (dec_phase == PH_DIGIT1)
            begin
                if (nib < 0)
                    dec_failed = 1'b1;
                else
                begin
                    val = {dec_hi, nib[3:0]};
                    data = 1'b1;
                    dec_phase = PH_PLAIN;
                end
            end
            else
            begin
                dec_phase = PH_PLAIN;
                if (dec_count >= cap_limit)
                    dec_failed = 1'b1;
                else if (c == CH_PLUS)
                begin
                    val = CH_SPACE;
                    data = 1'b1;
                end
                else if (c == CH_PERCENT)
                begin
                    if (!is_end)
                        dec_phase = PH_PCT;
                end
                else
                begin
                    val = c;
                    data = 1'b1;
                end
            end
            if (data)
                dec_count = dec_count + 16'd1;
        end
        if (data || is_end)
        begin
            res.out_byte = val;
            res.has_data = data;
            res.done_res = is_end;
            res.ok = is_end && !dec_failed;
            decoded_q.push_back(res);
        end
        if (is_end)
        begin
            dec_phase = PH_PLAIN;
            dec_hi = 4'h0;
            dec_count = 16'h0000;
            dec_failed = 1'b0;
        end
    endtask

    // sender: bursts of random length separated by random gaps
    always @(negedge clk)
    begin : drive_proc
        src_char_t it;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (source_q.size() != 0)
            begin
                it = source_q.pop_front();
                in_valid <= 1'b1;
                in_byte <= it.ch;
                is_last <= it.is_end;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 20);
                    if (tx_gap_max == 0 || $urandom_range(0, 2) == 0)
                        gap_left <= 0;
                    else
                        gap_left <= $urandom_range(1, tx_gap_max);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: stall pattern per mode, plus a long hold-off on request
    always @(negedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (hold_go != hold_seen)
        begin
            hold_seen <= hold_go;
            hold_left <= hold_len;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: out_ready <= ((rx_tick % 7) < 3);
                RX_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
                default:    out_ready <= 1'b1;
            endcase
        end
    end

    // result check first, then prediction of the input transfer in this cycle
    always @(posedge clk)
    begin : monitor_proc
        pud_result_t want;
        in_taken <= in_valid && in_ready;
        if (out_valid && out_ready)
        begin
            if (decoded_q.size() == 0)
                report_mismatch($sformatf("unexpected result byte %02h data %0b done %0b ok %0b",
                                          out_byte, has_data, done_res, ok));
            else
            begin
                want = decoded_q.pop_front();
                if (out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              out_byte, want.out_byte));
                if (has_data !== want.has_data)
                    report_mismatch($sformatf("has_data %0b, want %0b",
                                              has_data, want.has_data));
                if (done_res !== want.done_res)
                    report_mismatch($sformatf("done_res %0b, want %0b",
                                              done_res, want.done_res));
                if (ok !== want.ok)
                    report_mismatch($sformatf("ok %0b, want %0b", ok, want.ok));
            end
        end
        if (in_valid && in_ready)
            decode_char(in_byte, is_last);
    end

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 10)
            return CH_ZERO + v;
        return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + (v - 4'd10);
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (hex_nibble(c) >= 0)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic add_token();
        int         pick;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        c = 8'($urandom_range(0, 255));
        if (pick < 45)
            str_buf.push_back((c == CH_PERCENT) ? CH_PLUS : c);
        else if (pick < 60)
            str_buf.push_back(CH_PLUS);
        else
        begin
            str_buf.push_back(CH_PERCENT);
            str_buf.push_back(hex_char(c[7:4]));
            str_buf.push_back(hex_char(c[3:0]));
        end
    endtask

    task automatic flush_string();
        for (int i = 0; i < str_buf.size(); i++)
            source_q.push_back(src_char_t'{str_buf[i], i == str_buf.size() - 1});
    endtask

    task automatic send_text(input string s);
        str_buf.delete();
        for (int i = 0; i < s.len(); i++)
            str_buf.push_back(s[i]);
        flush_string();
    endtask

    task automatic queue_string(input int ntok, input str_kind_t kind);
        logic [7:0] v;
        str_buf.delete();
        v = 8'($urandom_range(0, 255));
        if (kind == STR_NOISE)
        begin
            repeat (ntok)
            begin
                case ($urandom_range(0, 3))
                    0: str_buf.push_back(CH_PERCENT);
                    1: str_buf.push_back(hex_char(4'($urandom_range(0, 15))));
                    default: str_buf.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
        else
        begin
            repeat (ntok) add_token();
            case (kind)
                STR_LONE_PCT:
                    str_buf.push_back(CH_PERCENT);
                STR_SHORT_ESC:
                begin
                    str_buf.push_back(CH_PERCENT);
                    str_buf.push_back(hex_char(v[3:0]));
                end
                STR_BAD_HEX:
                begin
                    str_buf.push_back(CH_PERCENT);
                    if (v[0])
                        str_buf.push_back(hex_char(v[7:4]));
                    str_buf.push_back(non_hex_char());
                    repeat ($urandom_range(0, 3)) add_token();
                end
                default: ;
            endcase
        end
        flush_string();
    endtask

    task automatic run_random(input int n_items, input int max_tok);
        int        queued;
        int        pick;
        int        ntok;
        str_kind_t kind;
        queued = 0;
        while (queued < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                kind = STR_CLEAN;
            else if (pick < 72)
                kind = STR_LONE_PCT;
            else if (pick < 79)
                kind = STR_SHORT_ESC;
            else if (pick < 88)
                kind = STR_BAD_HEX;
            else
                kind = STR_NOISE;
            if ($urandom_range(0, 9) == 0)
                ntok = $urandom_range(1, 40);
            else
                ntok = $urandom_range(1, max_tok);
            queue_string(ntok, kind);
            queued += str_buf.size();
        end
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        while (source_q.size() != 0 || in_valid)
            @(posedge clk);
        while (decoded_q.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        if (decoded_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d decoded results never arrived", decoded_q.size()));
            decoded_q.delete();
        end
        // characters with no result may still sit in the pipeline
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] cap);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_we <= 1'b0;
        cap_limit = cap;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed strings at the reset capacity
        send_text("+%4a%FFx");
        send_text("a%");
        send_text("%");
        send_text("%4");
        send_text("%g1z");
        send_text("%2G");
        source_q.push_back(src_char_t'{8'h00, 1'b1});
        source_q.push_back(src_char_t'{8'hFF, 1'b1});
        wait_idle();

        // exact fill succeeds, one byte over does not
        write_capacity(16'd2);
        rx_mode = RX_RANDOM;
        send_text("ab");
        send_text("a+c");
        wait_idle();

        write_capacity(16'hFFFF);
        tx_gap_max = 4;
        run_random(300, 10);
        wait_idle();

        write_capacity(16'd0);
        tx_gap_max = 0;
        rx_mode = RX_ALWAYS;
        run_random(80, 4);
        wait_idle();

        write_capacity(16'd1);
        tx_gap_max = 2;
        rx_mode = RX_PATTERN;
        run_random(100, 4);
        wait_idle();

        // long receiver hold-off so the input side backs up
        write_capacity(16'($urandom_range(2, 8)));
        tx_gap_max = 3;
        rx_mode = RX_RANDOM;
        hold_len = 200;
        hold_go = ~hold_go;
        run_random(300, 8);
        wait_idle();

        write_capacity(16'($urandom_range(9, 40)));
        tx_gap_max = 8;
        rx_mode = RX_SPARSE;
        run_random(150, 20);
        wait_idle();

        write_capacity(16'hFFFF);
        tx_gap_max = 0;
        rx_mode = RX_ALWAYS;
        run_random(250, 12);
        wait_idle();

        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/pud_pkg.sv
rtl/pud_step.sv
rtl/pud_out_stage.sv
rtl/percent_unescape_decoder.sv
rtl/pud_checker.sv
tb/tb_percent_unescape_decoder.sv
